FILE: sv/edrb_pkg.sv
// Package for the Ethernet DMA ring register block: constants, codes and register offsets.
package edrb_pkg;

  localparam int DescBytesDefault = 16;
  localparam int IndexBitsDefault = 12;

  localparam int OP_W    = 3;
  localparam int OFF_W   = 17;
  localparam int LEN_W   = 14;
  localparam int DIDX_W  = 12;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_TXDESC = 3'd2,
    OP_RXPKT = 3'd3,
    OP_LINK  = 3'd4
  } op_t;

  localparam logic [OFF_W-1:0] OFF_TX_BASE  = 17'h00800;
  localparam logic [OFF_W-1:0] OFF_TX_SIZE  = 17'h00804;
  localparam logic [OFF_W-1:0] OFF_TX_CPU   = 17'h00808;
  localparam logic [OFF_W-1:0] OFF_TX_DMA   = 17'h0080C;
  localparam logic [OFF_W-1:0] OFF_RX_BASE  = 17'h00900;
  localparam logic [OFF_W-1:0] OFF_RX_SIZE  = 17'h00904;
  localparam logic [OFF_W-1:0] OFF_RX_CPU   = 17'h00908;
  localparam logic [OFF_W-1:0] OFF_RX_DMA   = 17'h0090C;
  localparam logic [OFF_W-1:0] OFF_DMA_CFG  = 17'h00A04;
  localparam logic [OFF_W-1:0] OFF_INT_STAT = 17'h00A20;
  localparam logic [OFF_W-1:0] OFF_INT_MASK = 17'h00A28;
  localparam logic [OFF_W-1:0] OFF_CNT0     = 17'h00D00;
  localparam logic [OFF_W-1:0] OFF_CNT1     = 17'h00D04;
  localparam logic [OFF_W-1:0] OFF_CNT2     = 17'h00D08;
  localparam logic [OFF_W-1:0] OFF_CNT3     = 17'h00D0C;
  localparam logic [OFF_W-1:0] OFF_PHY_CMD  = 17'h100C0;
  localparam logic [OFF_W-1:0] OFF_PHY_RES  = 17'h100C4;

  // configuration register indexes
  localparam logic [1:0] CFG_PHY_ID_HIGH = 2'd0;
  localparam logic [1:0] CFG_PHY_ID_LOW  = 2'd1;
  localparam logic [1:0] CFG_RX_MAX_LEN  = 2'd2;

  localparam logic [15:0] PHY_ID_HIGH_RST = 16'hBADB;
  localparam logic [15:0] PHY_ID_LOW_RST  = 16'hADBA;
  localparam logic [13:0] RX_MAX_LEN_RST  = 14'd2048;

  // MII register values
  localparam logic [15:0] BMCR_DEF   = 16'h3100;
  localparam logic [15:0] BMSR_DEF   = 16'h7848;
  localparam logic [15:0] ANAR_DEF   = 16'h01E1;
  localparam logic [15:0] ANLPAR_DN  = 16'h0080;
  localparam logic [15:0] BMSR_LINK  = 16'h0024;
  localparam logic [15:0] ANLPAR_UP  = 16'h01E1;

endpackage

FILE: sv/eth_dma_ring_register_block_unit.sv
// Top level of the Ethernet DMA ring register block.
//
//  channel  dir  payload (low bit first)
//  s_axis   in   op, reg_offset, write_data, desc_buffer_addr, desc_info_word,
//                rx_length, link_up
//  m_axis   out  read_data, irq_line, fetch_tx_desc, desc_ring_addr, desc_index,
//                desc_writeback, desc_info_out, packet_go, packet_buffer_addr,
//                packet_length
//  cfg      in   cfg_we, cfg_index, cfg_data
//
// One beat is taken per cycle while m_axis is not stalled; its result shows in the output register the
// cycle after acceptance, set by the single register update pass.
// A new beat is accepted whenever the output register is empty or drains in
// the same cycle. rst is synchronous; it clears ring, DMA, IRQ, counter and PHY command/result state,
// sets PHY and cfg defaults, link comes up. A stall on m_axis holds the result and backs up s_axis, no more.
module eth_dma_ring_register_block_unit
  import edrb_pkg::*;
#(
  parameter int DESC_BYTES = DescBytesDefault,
  parameter int INDEX_BITS = IndexBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], reg_offset[19:3], write_data[51:20], desc_buffer_addr[83:52],
  // desc_info_word[115:84], rx_length[129:116], link_up[130], zero pad
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_data[31:0], irq_line[32], fetch_tx_desc[33], desc_ring_addr[65:34],
  // desc_index[77:66], desc_writeback[78], desc_info_out[110:79],
  // packet_go[111], packet_buffer_addr[143:112], packet_length[157:144], pad
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int IW = INDEX_BITS;

  // input fields
  logic [OP_W-1:0]  op;
  logic [OFF_W-1:0] reg_offset;
  logic [31:0]      write_data, desc_buffer_addr, desc_info_word;
  logic [LEN_W-1:0] rx_length;
  logic             link_up;

  assign op               = s_axis_tdata[2:0];
  assign reg_offset       = s_axis_tdata[19:3];
  assign write_data       = s_axis_tdata[51:20];
  assign desc_buffer_addr = s_axis_tdata[83:52];
  assign desc_info_word   = s_axis_tdata[115:84];
  assign rx_length        = s_axis_tdata[129:116];
  assign link_up          = s_axis_tdata[130];

  // state
  logic [15:0]   phy_id_high, phy_id_low;
  logic [13:0]   rx_max_len;
  logic [31:0]   tx_base_addr, rx_base_addr;
  logic [IW-1:0] tx_ring_size, tx_cpu_index, tx_dma_index;
  logic [IW-1:0] rx_ring_size, rx_cpu_index, rx_dma_index;
  logic [1:0]    dma_enables;
  logic          tx_wait_desc;
  logic [31:0]   irq_status, irq_enable;
  logic [31:0]   traffic_counters [4];
  logic [27:0]   phy_command;
  logic [17:0]   phy_result;
  logic [15:0]   phy_regs [4];
  logic          link_state;

  logic [31:0]   tx_base_addr_next, rx_base_addr_next;
  logic [IW-1:0] tx_ring_size_next, tx_cpu_index_next, tx_dma_index_next;
  logic [IW-1:0] rx_ring_size_next, rx_cpu_index_next, rx_dma_index_next;
  logic [1:0]    dma_enables_next;
  logic          tx_wait_desc_next;
  logic [31:0]   irq_status_next, irq_enable_next;
  logic [31:0]   traffic_counters_next [4];
  logic [27:0]   phy_command_next;
  logic [17:0]   phy_result_next;
  logic [15:0]   phy_regs_next [4];
  logic          link_state_next;

  // result fields
  logic [31:0]      read_data, desc_ring_addr, desc_info_out, packet_buffer_addr;
  logic             irq_line, fetch_tx_desc, desc_writeback, packet_go;
  logic [DIDX_W-1:0] desc_index;
  logic [LEN_W-1:0] packet_length;

  logic        take;
  logic [159:0] out_reg;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = out_reg;

  // shared helpers
  logic [IW-1:0] wd_idx, tx_prev, rx_next_cpu, tx_dma_adv, rx_dma_adv;
  logic [IW:0]   tx_cpu_p1, tx_dma_p1, rx_dma_p1;
  logic [31:0]   tx_addr_new, tx_addr_cur, rx_addr_cur;
  logic [13:0]   tx_len;
  logic [4:0]    pc_reg;
  logic [15:0]   pc_data, pc_rd;
  logic          rx_ok, tx_ok;

  assign wd_idx      = write_data[IW-1:0];
  assign tx_prev     = (wd_idx == '0) ? tx_ring_size - 1'b1 : wd_idx - 1'b1;
  assign tx_cpu_p1   = {1'b0, wd_idx} + 1'b1;
  assign rx_next_cpu = (tx_cpu_p1 >= {1'b0, rx_ring_size}) ? '0 : tx_cpu_p1[IW-1:0];
  assign tx_dma_p1   = {1'b0, tx_dma_index} + 1'b1;
  assign tx_dma_adv  = (tx_dma_p1 >= {1'b0, tx_ring_size}) ? '0 : tx_dma_p1[IW-1:0];
  assign rx_dma_p1   = {1'b0, rx_dma_index} + 1'b1;
  assign rx_dma_adv  = (rx_dma_p1 >= {1'b0, rx_ring_size}) ? '0 : rx_dma_p1[IW-1:0];
  assign tx_addr_new = tx_base_addr + 32'(DESC_BYTES) * 32'(tx_prev);
  assign tx_addr_cur = tx_base_addr + 32'(DESC_BYTES) * 32'(tx_dma_index);
  assign rx_addr_cur = rx_base_addr + 32'(DESC_BYTES) * 32'(rx_dma_index);
  assign tx_len      = desc_info_word[29:16];
  assign pc_reg      = write_data[12:8];
  assign pc_data     = write_data[31:16];
  assign tx_ok = desc_buffer_addr != '0 && !desc_info_word[31] && tx_len != '0;
  assign rx_ok = dma_enables[1] && rx_base_addr != '0 && rx_ring_size != '0 &&
                 rx_dma_index < rx_ring_size && rx_cpu_index < rx_ring_size &&
                 rx_cpu_index != rx_dma_index && desc_buffer_addr != '0 &&
                 !desc_info_word[31] && rx_length <= rx_max_len;

  // PHY read value
  always_comb begin
    unique case (pc_reg)
      5'd0:    pc_rd = phy_regs[0];
      5'd1:    pc_rd = phy_regs[1];
      5'd2:    pc_rd = phy_id_high;
      5'd3:    pc_rd = phy_id_low;
      5'd4:    pc_rd = phy_regs[2];
      5'd5:    pc_rd = phy_regs[3];
      default: pc_rd = phy_result[15:0];
    endcase
  end

  // one update pass per beat
  always_comb begin
    logic [17:0] pr_t;
    logic [15:0] bmsr_t;
    tx_base_addr_next = tx_base_addr;  rx_base_addr_next = rx_base_addr;
    tx_ring_size_next = tx_ring_size;  rx_ring_size_next = rx_ring_size;
    tx_cpu_index_next = tx_cpu_index;  rx_cpu_index_next = rx_cpu_index;
    tx_dma_index_next = tx_dma_index;  rx_dma_index_next = rx_dma_index;
    dma_enables_next = dma_enables;    tx_wait_desc_next = tx_wait_desc;
    irq_status_next = irq_status;      irq_enable_next = irq_enable;
    for (int k = 0; k < 4; k++) begin
      traffic_counters_next[k] = traffic_counters[k];
      phy_regs_next[k] = phy_regs[k];
    end
    phy_command_next = phy_command;    phy_result_next = phy_result;
    link_state_next = link_state;
    read_data = '0; fetch_tx_desc = 1'b0; desc_ring_addr = '0; desc_index = '0;
    desc_writeback = 1'b0; desc_info_out = '0; packet_go = 1'b0;
    packet_buffer_addr = '0; packet_length = '0;
    pr_t = '0; bmsr_t = '0;

    unique case (op)
      OP_READ: begin
        unique case (reg_offset)
          OFF_TX_BASE:  read_data = tx_base_addr;
          OFF_TX_SIZE:  read_data = 32'(tx_ring_size);
          OFF_TX_CPU:   read_data = 32'(tx_cpu_index);
          OFF_TX_DMA:   read_data = 32'(tx_dma_index);
          OFF_RX_BASE:  read_data = rx_base_addr;
          OFF_RX_SIZE:  read_data = 32'(rx_ring_size);
          OFF_RX_CPU:   read_data = 32'(rx_cpu_index);
          OFF_RX_DMA:   read_data = 32'(rx_dma_index);
          OFF_DMA_CFG:  read_data = {29'd0, dma_enables[1], tx_wait_desc, dma_enables[0]};
          OFF_INT_STAT: read_data = irq_status;
          OFF_INT_MASK: read_data = irq_enable;
          OFF_CNT0:     read_data = traffic_counters[0];
          OFF_CNT1:     read_data = traffic_counters[1];
          OFF_CNT2:     read_data = traffic_counters[2];
          OFF_CNT3:     read_data = traffic_counters[3];
          OFF_PHY_CMD:  read_data = {phy_command[27:12], 1'b0, phy_command[11],
                                     phy_command[10], phy_command[9:5], 3'd0,
                                     phy_command[4:0]};
          OFF_PHY_RES: begin
            // status bits toggle on every read
            pr_t = phy_result ^ 18'h30000;
            phy_result_next = pr_t;
            read_data = {pr_t[15:0], 14'd0, pr_t[17], pr_t[16]};
          end
          default: read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (reg_offset)
          OFF_TX_BASE: tx_base_addr_next = write_data;
          OFF_TX_SIZE: tx_ring_size_next = wd_idx;
          OFF_TX_CPU: begin
            tx_cpu_index_next = wd_idx;
            tx_dma_index_next = tx_prev;
            if (dma_enables[0] && !tx_wait_desc && tx_base_addr != '0 &&
                tx_ring_size != '0 && tx_prev < tx_ring_size &&
                wd_idx < tx_ring_size) begin
              tx_wait_desc_next = 1'b1;
              fetch_tx_desc = 1'b1;
              desc_ring_addr = tx_addr_new;
              desc_index = DIDX_W'(tx_prev);
            end
          end
          OFF_RX_BASE: rx_base_addr_next = write_data;
          OFF_RX_SIZE: rx_ring_size_next = wd_idx;
          OFF_RX_CPU: begin
            rx_cpu_index_next = wd_idx;
            rx_dma_index_next = rx_next_cpu;
          end
          OFF_RX_DMA:   rx_dma_index_next = wd_idx;
          OFF_DMA_CFG:  dma_enables_next = {write_data[2], write_data[0]};
          OFF_INT_STAT: irq_status_next = irq_status & ~write_data;
          OFF_INT_MASK: irq_enable_next = write_data;
          OFF_PHY_CMD: begin
            if (write_data[14]) phy_result_next = {phy_result[17:16], pc_rd};
            if (write_data[13]) begin
              if (pc_reg == 5'd0) begin
                if (pc_data[15]) begin
                  // MII defaults for the present link
                  phy_regs_next[0] = BMCR_DEF;
                  phy_regs_next[1] = link_state ? (BMSR_DEF | BMSR_LINK)
                                                : (BMSR_DEF & ~BMSR_LINK);
                  phy_regs_next[2] = ANAR_DEF;
                  phy_regs_next[3] = link_state ? (ANLPAR_DN | ANLPAR_UP) : ANLPAR_DN;
                end else begin
                  phy_regs_next[0] = pc_data;
                end
              end else if (pc_reg == 5'd4) begin
                phy_regs_next[2] = pc_data;
              end
            end
            // command flags are not kept
            phy_command_next = {pc_data, 2'b00, pc_reg, write_data[4:0]};
          end
          OFF_PHY_RES: phy_result_next = {write_data[1:0], phy_result[15:0]};
          default: ;
        endcase
      end
      OP_TXDESC: begin
        if (tx_wait_desc) begin
          tx_wait_desc_next = 1'b0;
          if (tx_ok) begin
            desc_ring_addr = tx_addr_cur;
            desc_index = DIDX_W'(tx_dma_index);
            desc_writeback = 1'b1;
            desc_info_out = desc_info_word | 32'h8000_0000;
            packet_go = 1'b1;
            packet_buffer_addr = desc_buffer_addr;
            packet_length = tx_len;
            traffic_counters_next[0] = traffic_counters[0] + 32'd1;
            traffic_counters_next[1] = traffic_counters[1] + 32'(tx_len);
            irq_status_next = irq_status | 32'h1;
            tx_dma_index_next = tx_dma_adv;
          end
        end
      end
      OP_RXPKT: begin
        if (rx_ok) begin
          desc_ring_addr = rx_addr_cur;
          desc_index = DIDX_W'(rx_dma_index);
          desc_writeback = 1'b1;
          desc_info_out = desc_info_word | {2'b10, rx_length, 16'd0};
          packet_go = 1'b1;
          packet_buffer_addr = desc_buffer_addr;
          packet_length = rx_length;
          traffic_counters_next[2] = traffic_counters[2] + 32'd1;
          traffic_counters_next[3] = traffic_counters[3] + 32'(rx_length);
          irq_status_next = irq_status | 32'h10000;
          rx_dma_index_next = rx_dma_adv;
        end
      end
      OP_LINK: begin
        link_state_next = link_up;
        bmsr_t = link_up ? (phy_regs[1] | BMSR_LINK) : (phy_regs[1] & ~BMSR_LINK);
        phy_regs_next[1] = bmsr_t;
        phy_regs_next[3] = link_up ? (phy_regs[3] | ANLPAR_UP) : ANLPAR_DN;
      end
      default: ;
    endcase
    irq_line = (irq_status_next & irq_enable_next) != '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_base_addr <= '0; tx_ring_size <= '0; tx_cpu_index <= '0; tx_dma_index <= '0;
      rx_base_addr <= '0; rx_ring_size <= '0; rx_cpu_index <= '0; rx_dma_index <= '0;
      dma_enables <= '0; tx_wait_desc <= 1'b0; irq_status <= '0; irq_enable <= '0;
      for (int k = 0; k < 4; k++) traffic_counters[k] <= '0;
      phy_command <= '0; phy_result <= '0; link_state <= 1'b1;
      phy_regs[0] <= BMCR_DEF;
      phy_regs[1] <= BMSR_DEF | BMSR_LINK;
      phy_regs[2] <= ANAR_DEF;
      phy_regs[3] <= ANLPAR_DN | ANLPAR_UP;
    end else if (take) begin
      tx_base_addr <= tx_base_addr_next; tx_ring_size <= tx_ring_size_next;
      tx_cpu_index <= tx_cpu_index_next; tx_dma_index <= tx_dma_index_next;
      rx_base_addr <= rx_base_addr_next; rx_ring_size <= rx_ring_size_next;
      rx_cpu_index <= rx_cpu_index_next; rx_dma_index <= rx_dma_index_next;
      dma_enables <= dma_enables_next; tx_wait_desc <= tx_wait_desc_next;
      irq_status <= irq_status_next; irq_enable <= irq_enable_next;
      for (int k = 0; k < 4; k++) begin
        traffic_counters[k] <= traffic_counters_next[k];
        phy_regs[k] <= phy_regs_next[k];
      end
      phy_command <= phy_command_next; phy_result <= phy_result_next;
      link_state <= link_state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phy_id_high <= PHY_ID_HIGH_RST;
      phy_id_low  <= PHY_ID_LOW_RST;
      rx_max_len  <= RX_MAX_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PHY_ID_HIGH) phy_id_high <= cfg_data;
      if (cfg_index == CFG_PHY_ID_LOW)  phy_id_low  <= cfg_data;
      if (cfg_index == CFG_RX_MAX_LEN)  rx_max_len  <= cfg_data[13:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= {2'd0, packet_length, packet_buffer_addr, packet_go, desc_info_out,
                  desc_writeback, desc_index, desc_ring_addr, fetch_tx_desc,
                  irq_line, read_data};
    end
  end

`ifndef SYNTHESIS
  // a fetch request only goes out when none was pending
  a_fetch_once: assert property (@(posedge clk) disable iff (rst)
    take && fetch_tx_desc |-> !tx_wait_desc) else $error("fetch while pending");
  // a fetch leaves a descriptor pending
  a_fetch_pend: assert property (@(posedge clk) disable iff (rst)
    take && fetch_tx_desc |=> tx_wait_desc) else $error("fetch not pending");
  // every sent or stored packet writes its descriptor back
  a_go_wb: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_reg[111] == out_reg[78]) else $error("go without writeback");
  // held result is not overwritten during a stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(out_reg)) else $error("result lost");
`endif

endmodule
